>>> rtl/tssf_pkg.sv
// package for the touch sample settle filter
// item types, configuration types and fixed constants; no dependencies
`timescale 1ns / 1ps

package tssf_pkg;

  localparam int unsigned RawW    = 16;
  localparam int unsigned SampleW = 13;
  localparam int unsigned SizeW   = 5;
  localparam int unsigned LimitW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SampleW-1:0] MinSeed       = 13'd5000;
  localparam logic [SizeW-1:0]   SizeLow       = 5'd3;
  localparam logic [SizeW-1:0]   SizeMaxClamp  = 5'd18;
  localparam logic [SizeW-1:0]   SizeFloor     = 5'd1;

  localparam logic [SizeW-1:0]   WindowSizeRst  = 5'd10;
  localparam logic [SampleW-1:0] SpreadLimitRst = 13'd40;
  localparam logic [LimitW-1:0]  WindowLimitRst = 4'd10;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_SPREAD_LIMIT = 2'd1,
    CFG_WINDOW_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_word;
    logic            start_req;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] filtered_value;
    logic               settled;
  } out_item_t;

  typedef struct packed {
    logic [SizeW-1:0]   window_size;
    logic [SampleW-1:0] spread_limit;
    logic [LimitW-1:0]  window_limit;
  } cfg_t;

  typedef struct packed {
    logic             measuring;
    logic [SizeW-1:0] sample_count;
  } status_t;

endpackage

>>> rtl/tssf_core.sv
// filter state and per-item update: running average, window min/max, counters
// depends on tssf_pkg
`timescale 1ns / 1ps

module tssf_core import tssf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      emit_o,
  output out_item_t result_o,
  output status_t   status_o
);

  logic [SampleW-1:0] avg_q, avg_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SizeW-1:0]   cnt_q, cnt_d;
  logic [LimitW-1:0]  wc_q, wc_d;
  logic               meas_q, meas_d;

  logic [SampleW-1:0] sample;
  logic [SampleW+2:0] avg_sum;
  logic [SampleW-1:0] avg_new, min_new, max_new, spread;
  logic [SizeW-1:0]   cnt_new, eff_size;
  logic [LimitW-1:0]  wc_new;

  assign sample  = item_i.raw_word[RawW-1:RawW-SampleW];
  // 3*avg + s, then divide by four
  assign avg_sum = {3'b000, avg_q} + {2'b00, avg_q, 1'b0} + {3'b000, sample};
  assign avg_new = avg_sum[SampleW+1:2];
  assign min_new = (sample < min_q) ? sample : min_q;
  assign max_new = (sample > max_q) ? sample : max_q;
  assign cnt_new = cnt_q + 1'b1;
  assign wc_new  = wc_q + 1'b1;
  assign spread  = (max_new >= min_new) ? (max_new - min_new) : '0;

  always_comb begin
    if (cfg_i.window_size < SizeLow) begin
      eff_size = SizeFloor;
    end else if (cfg_i.window_size > SizeMaxClamp) begin
      eff_size = SizeMaxClamp;
    end else begin
      eff_size = cfg_i.window_size;
    end
  end

  always_comb begin
    avg_d    = avg_q;
    min_d    = min_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    wc_d     = wc_q;
    meas_d   = meas_q;
    emit_o   = 1'b0;
    result_o = '0;
    if (item_i.start_req) begin
      // dummy read seeds the average
      avg_d  = sample;
      min_d  = MinSeed;
      max_d  = '0;
      cnt_d  = '0;
      wc_d   = '0;
      if (cfg_i.window_limit == '0) begin
        meas_d   = 1'b0;
        emit_o   = 1'b1;
        result_o = '{filtered_value: sample, settled: 1'b0};
      end else begin
        meas_d = 1'b1;
      end
    end else if (meas_q) begin
      avg_d = avg_new;
      min_d = min_new;
      max_d = max_new;
      cnt_d = cnt_new;
      if (cnt_new >= eff_size) begin
        if (spread < cfg_i.spread_limit) begin
          meas_d   = 1'b0;
          emit_o   = 1'b1;
          result_o = '{filtered_value: avg_new, settled: 1'b1};
        end else begin
          wc_d = wc_new;
          if (wc_new >= cfg_i.window_limit) begin
            meas_d   = 1'b0;
            emit_o   = 1'b1;
            result_o = '{filtered_value: avg_new, settled: 1'b0};
          end else begin
            // window failed, open a fresh one
            min_d = MinSeed;
            max_d = '0;
            cnt_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      min_q  <= MinSeed;
      max_q  <= '0;
      cnt_q  <= '0;
      wc_q   <= '0;
      meas_q <= 1'b0;
    end else if (adv_i) begin
      avg_q  <= avg_d;
      min_q  <= min_d;
      max_q  <= max_d;
      cnt_q  <= cnt_d;
      wc_q   <= wc_d;
      meas_q <= meas_d;
    end
  end

  assign status_o = '{measuring: meas_q, sample_count: cnt_q};

endmodule

>>> rtl/touch_sample_settle_filter.sv
// touch sample settle filter top level: input register, filter core, result register
// a result is registered as the item ending a measurement leaves the input register
// throughput: one item per cycle; an item stalls only when a result waits in the output
// register and the core would produce another one in the same cycle
// reset: state idle, average 0, window min 5000, registers 10 / 40 / 10
// depends on tssf_pkg and tssf_core
`timescale 1ns / 1ps

module touch_sample_settle_filter import tssf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SampleW-1:0]  cfg_wdata_i
);

  cfg_t      cfg_q;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t out_item_q;
  logic      out_valid_q;

  logic      s1_adv;
  logic      emit;
  out_item_t result;
  status_t   status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{window_size: WindowSizeRst, spread_limit: SpreadLimitRst,
                 window_limit: WindowLimitRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SIZE:  cfg_q.window_size  <= cfg_wdata_i[SizeW-1:0];
        CFG_SPREAD_LIMIT: cfg_q.spread_limit <= cfg_wdata_i;
        CFG_WINDOW_LIMIT: cfg_q.window_limit <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // item in stage 1 moves on unless its result would overrun a held output
  assign s1_adv     = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  tssf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (result),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_emit_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && emit |=> out_valid_q)
    else $error("result of an advancing item did not reach the output register");

  a_emit_ends_meas : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && emit |=> !status.measuring)
    else $error("measurement still running after a result");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.sample_count <= SizeMaxClamp)
    else $error("sample count ran past the largest window");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |-> out_valid_q && !out_ready_i && emit)
    else $error("stage 1 stalled without a blocked result");

endmodule

>>> dv/tb_top.sv
// testbench for the touch sample settle filter: random and directed words, scoreboard of readings
// holds its own predictor of the filter; depends on tssf_pkg and touch_sample_settle_filter
`timescale 1ns / 1ps

module tb_top;
  import tssf_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [SampleW-1:0]  cfg_wdata_i = '0;

  touch_sample_settle_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  in_item_t  pending_words[$];
  out_item_t expected_readings[$];
  int        err_cnt = 0;
  bit        idle_en = 1'b1;

  // predictor copy of registers and filter state
  logic [SizeW-1:0]   win_size_m  = WindowSizeRst;
  logic [SampleW-1:0] spread_lim_m = SpreadLimitRst;
  logic [LimitW-1:0]  win_limit_m = WindowLimitRst;
  logic [SampleW-1:0] avg_m       = '0;
  logic [SampleW-1:0] win_min_m   = MinSeed;
  logic [SampleW-1:0] win_max_m   = '0;
  logic [SizeW-1:0]   sample_cnt_m = '0;
  logic [LimitW-1:0]  window_cnt_m = '0;
  logic               measuring_m = 1'b0;

  function automatic int unsigned eff_size(logic [SizeW-1:0] ws);
    if (ws < SizeLow) return SizeFloor;
    if (ws > SizeMaxClamp) return SizeMaxClamp;
    return ws;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_reading(logic [SampleW-1:0] value, logic settled);
    out_item_t res;
    res.filtered_value = value;
    res.settled        = settled;
    expected_readings.push_back(res);
  endtask

  task automatic predict_reading(in_item_t it);
    logic [SampleW-1:0] s;
    int unsigned        acc;
    int unsigned        spread;
    s = it.raw_word[RawW-1:3];
    if (it.start_req) begin
      avg_m        = s;
      win_min_m    = MinSeed;
      win_max_m    = '0;
      sample_cnt_m = '0;
      window_cnt_m = '0;
      if (win_limit_m == '0) begin
        // no windows allowed: seed comes straight back unsettled
        measuring_m = 1'b0;
        report_reading(avg_m, 1'b0);
      end else begin
        measuring_m = 1'b1;
      end
    end else if (measuring_m) begin
      acc   = 32'(avg_m) * 3 + 32'(s);
      avg_m = acc[14:2];
      if (s < win_min_m) win_min_m = s;
      if (s > win_max_m) win_max_m = s;
      sample_cnt_m = sample_cnt_m + 1'b1;
      if (sample_cnt_m >= eff_size(win_size_m)) begin
        spread = (win_max_m >= win_min_m) ? 32'(win_max_m) - 32'(win_min_m) : 0;
        if (spread < spread_lim_m) begin
          measuring_m = 1'b0;
          report_reading(avg_m, 1'b1);
        end else begin
          window_cnt_m = window_cnt_m + 1'b1;
          if (window_cnt_m >= win_limit_m) begin
            measuring_m = 1'b0;
            report_reading(avg_m, 1'b0);
          end else begin
            win_min_m    = MinSeed;
            win_max_m    = '0;
            sample_cnt_m = '0;
          end
        end
      end
    end
  endtask

  // input driver
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_item_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_gap     <= idle_en ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int out_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else if (out_stall != 0) begin
      out_stall   <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_en && $urandom_range(0, 3) == 0) out_stall <= pick_gap();
    end
  end

  // monitor: predict on accepted words, check accepted readings
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_reading(in_item_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual value %0d settled %0b",
                   $time, out_item_o.filtered_value, out_item_o.settled);
          err_cnt++;
        end else begin
          want = expected_readings.pop_front();
          if (out_item_o.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                     $time, want.filtered_value, out_item_o.filtered_value);
            err_cnt++;
          end
          if (out_item_o.settled !== want.settled) begin
            $display("%0t: settled mismatch, expected %0b, actual %0b",
                     $time, want.settled, out_item_o.settled);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [SampleW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WINDOW_SIZE:  win_size_m   = val[SizeW-1:0];
      CFG_SPREAD_LIMIT: spread_lim_m = val;
      CFG_WINDOW_LIMIT: win_limit_m  = val[LimitW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned ws, int unsigned sl, int unsigned wl);
    write_reg(CFG_WINDOW_SIZE, SampleW'(ws));
    write_reg(CFG_SPREAD_LIMIT, SampleW'(sl));
    write_reg(CFG_WINDOW_LIMIT, SampleW'(wl));
  endtask

  task automatic push_word(logic [RawW-1:0] raw, logic start);
    in_item_t it;
    it.raw_word  = raw;
    it.start_req = start;
    pending_words.push_back(it);
  endtask

  // let the block drain, including words that produce nothing
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [RawW-1:0] sample_word(int s);
    if (s < 0) s = 0;
    if (s > 8191) s = 8191;
    return {13'(s), 3'($urandom_range(0, 7))};
  endfunction

  int items_sent = 0;

  task automatic push_measurement(int unsigned ws, int unsigned wl);
    int unsigned maxw;
    int unsigned n;
    int          center;
    int          jitter;
    maxw = eff_size(SizeW'(ws)) * ((wl == 0) ? 1 : wl) + 2;
    if (maxw > 60 && $urandom_range(0, 3) != 0) maxw = 60;
    n = $urandom_range(0, maxw);
    case ($urandom_range(0, 5))
      0: center = 0;
      1: center = 8191;
      2: center = $urandom_range(4990, 5010);
      default: center = $urandom_range(0, 8191);
    endcase
    case ($urandom_range(0, 4))
      0: jitter = 0;
      1: jitter = $urandom_range(0, 3);
      2: jitter = $urandom_range(0, 40);
      3: jitter = $urandom_range(0, 500);
      default: jitter = 4095;
    endcase
    push_word(sample_word(center), 1'b1);
    for (int i = 0; i < n; i++)
      push_word(sample_word(center + $urandom_range(0, 2 * jitter) - jitter), 1'b0);
    items_sent += n + 1;
  endtask

  initial begin
    int unsigned ws;
    int unsigned sl;
    int unsigned wl;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values first
    push_word(16'hFFFF, 1'b1);
    for (int i = 0; i < 3; i++) push_word(16'(40000 + 8 * i), 1'b0);
    wait_drained();

    // single-sample windows, widest limit: settle on the first word
    set_config(0, 8191, 1);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'h1234, 1'b0);
    push_word(16'h0000, 1'b1);
    push_word(16'h0007, 1'b1);
    push_word(16'hFFFF, 1'b0);
    wait_drained();

    // zero window limit reports the seed at once
    set_config(2, 8191, 0);
    push_word(16'hABCD, 1'b1);
    push_word(16'h5555, 1'b0);
    wait_drained();

    // zero spread limit never settles: windows run out
    set_config(3, 0, 2);
    push_word(16'h8000, 1'b1);
    for (int i = 0; i < 6; i++) push_word(16'($urandom_range(0, 65535)), 1'b0);
    wait_drained();

    // samples at or above the min seed never lower the minimum
    set_config(4, 100, 1);
    push_word(16'hFFF8, 1'b1);
    for (int i = 0; i < 4; i++) push_word(16'(40000 + 8 * i), 1'b0);
    wait_drained();

    while (items_sent < 1500) begin
      case ($urandom_range(0, 7))
        0: ws = 0;
        1: ws = 1;
        2: ws = 2;
        3: ws = 3;
        4: ws = 18;
        5: ws = 19;
        6: ws = 31;
        default: ws = $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 5))
        0: sl = 0;
        1: sl = 1;
        2: sl = 8191;
        3: sl = $urandom_range(0, 8191);
        default: sl = $urandom_range(2, 120);
      endcase
      case ($urandom_range(0, 7))
        0: wl = 0;
        1: wl = 1;
        2: wl = 15;
        default: wl = $urandom_range(1, 15);
      endcase
      set_config(ws, sl, wl);
      idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) begin
        // now and then some noise or a broken sequence
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            push_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
        push_measurement(ws, wl);
      end
      wait_drained();
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("PASS touch_sample_settle_filter");
    end else begin
      $display("FAIL touch_sample_settle_filter");
    end
    $finish;
  end

  initial begin
    #9_600_000;
    $display("FAIL touch_sample_settle_filter");
    $finish;
  end

endmodule

>>> files.f
rtl/tssf_pkg.sv
rtl/tssf_core.sv
rtl/touch_sample_settle_filter.sv
dv/tb_top.sv
